### hdl/mml_pkg.sv
// Package for the min/max load assignment block.
// Holds sizing constants, the search state type and the chain control struct.
// No dependencies.
`default_nettype none
package mml_pkg;
   localparam int MAX_CARRIERS_DEF = 256;
   localparam int MAX_ITEMS_DEF    = 1024;
   localparam int AMOUNT_W         = 24;
   localparam int LIMIT_W          = 11;
   localparam int TIME_W           = 12;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CHECK,
      ST_RESTORE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic insert;
      logic rotate;
   } chain_ctl_type;
endpackage
`default_nettype wire

### hdl/mml_ifs.sv
// Request and response channel interfaces for the load assignment block.
// Depends on mml_pkg for field widths.
`default_nettype none
interface mml_req_if;
   logic                          valid;
   logic                          ready;
   logic                          is_item;
   logic [mml_pkg::AMOUNT_W-1:0]  amount;
   logic                          last;
   modport source (output valid, is_item, amount, last, input ready);
   modport sink   (input valid, is_item, amount, last, output ready);
endinterface

interface mml_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          possible;
   logic [mml_pkg::LIMIT_W-1:0]   per_carrier_limit;
   logic [mml_pkg::TIME_W-1:0]    total_time;
   modport source (output valid, possible, per_carrier_limit, total_time, input ready);
   modport sink   (input valid, possible, per_carrier_limit, total_time, output ready);
endinterface
`default_nettype wire

### hdl/mml_cell.sv
// One cell of a sorted chain: holds one value, inserts in order or rotates.
// Depends on mml_pkg.
`default_nettype none
module mml_cell (
   input  wire logic                          clock,
   input  wire mml_pkg::chain_ctl_type        ctl,
   input  wire logic                          valid,
   input  wire logic [mml_pkg::AMOUNT_W-1:0]  new_value,
   input  wire logic [mml_pkg::AMOUNT_W-1:0]  prev_value,
   input  wire logic                          prev_keep,
   input  wire logic [mml_pkg::AMOUNT_W-1:0]  next_value,
   output logic [mml_pkg::AMOUNT_W-1:0]       value,
   output logic                               keep
);
   import mml_pkg::*;

   logic [AMOUNT_W-1:0] value_ff;
   logic [AMOUNT_W-1:0] value_in;

   // equal values stay ahead of the newcomer
   assign keep  = valid && (value_ff <= new_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.insert) begin
         if (keep) begin
            value_in = value_ff;
         end else if (prev_keep) begin
            value_in = new_value;
         end else begin
            value_in = prev_value;
         end
      end else if (ctl.rotate) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end
endmodule
`default_nettype wire

### hdl/mml_chain.sv
// Row of mml_cell forming a sorted list that can rotate towards its head.
// Depends on mml_pkg and mml_cell.
`default_nettype none
module mml_chain #(
   parameter int DEPTH = mml_pkg::MAX_ITEMS_DEF,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                          clock,
   input  wire mml_pkg::chain_ctl_type        ctl,
   input  wire logic [CNT_W-1:0]              count,
   input  wire logic [mml_pkg::AMOUNT_W-1:0]  new_value,
   output logic [mml_pkg::AMOUNT_W-1:0]       head
);
   import mml_pkg::*;

   logic [AMOUNT_W-1:0] vals  [DEPTH];
   logic                keeps [DEPTH];

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic                valid;
      logic [AMOUNT_W-1:0] prev_v;
      logic                prev_k;
      logic [AMOUNT_W-1:0] next_v;

      assign valid  = count > CNT_W'(j);
      assign prev_v = (j == 0) ? new_value : vals[(j == 0) ? 0 : j - 1];
      assign prev_k = (j == 0) ? 1'b1 : keeps[(j == 0) ? 0 : j - 1];
      assign next_v = vals[(j == DEPTH - 1) ? 0 : j + 1];

      mml_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .valid      (valid),
         .new_value  (new_value),
         .prev_value (prev_v),
         .prev_keep  (prev_k),
         .next_value (next_v),
         .value      (vals[j]),
         .keep       (keeps[j])
      );
   end

   assign head = vals[0];
endmodule
`default_nettype wire

### hdl/min_max_load_assignment.sv
// Top level: collects capacities and weights into two sorted cell chains,
// then binary-searches the smallest per-carrier item limit with a greedy walk.
// Depends on mml_pkg, mml_ifs, mml_chain.
//
//   channel | dir | payload
//   req     | in  | is_item, amount, last
//   rsp     | out | possible, per_carrier_limit, total_time
//
// Values load at one request per cycle; a full store drops the value.
// After the last request each greedy check walks the chains, then rotates both
// chains a full turn back to their heads, and the search runs at most
// 1 + ceil(log2(item count)) checks; an empty item set skips the search.
// req.ready is low during the search and while a result waits for the previous
// response to be taken; a waiting response does not block loading.
// Reset is synchronous and clears counts and control; chain contents are not cleared.
`default_nettype none
module min_max_load_assignment #(
   parameter int MAX_CARRIERS = mml_pkg::MAX_CARRIERS_DEF,
   parameter int MAX_ITEMS    = mml_pkg::MAX_ITEMS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mml_req_if.sink    req,
   mml_rsp_if.source  rsp
);
   import mml_pkg::*;

   localparam int CW = $clog2(MAX_CARRIERS + 1);
   localparam int IW = $clog2(MAX_ITEMS + 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  cc_ff, cc_in, c_ff, c_in;
   logic [IW-1:0]  ic_ff, ic_in, i_ff, i_in;
   logic [IW-1:0]  load_ff, load_in, k_ff, k_in;
   logic [IW-1:0]  low_ff, low_in, high_ff, high_in;
   logic           first_ff, first_in, ok_ff, ok_in;
   logic           rsp_vld_ff, rsp_vld_in;
   logic           rsp_pos_ff, rsp_pos_in;
   logic [LIMIT_W-1:0] rsp_lim_ff, rsp_lim_in;
   logic [TIME_W-1:0]  rsp_time_ff, rsp_time_in;

   chain_ctl_type       car_ctl, itm_ctl;
   logic [AMOUNT_W-1:0] car_head, itm_head;
   logic                accept;
   logic [TIME_W-1:0]   k12;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_LOAD);
   assign k12       = TIME_W'(k_ff);

   mml_chain #(.DEPTH(MAX_CARRIERS), .CNT_W(CW)) u_carriers (
      .clock(clock), .ctl(car_ctl), .count(cc_ff), .new_value(req.amount), .head(car_head)
   );

   mml_chain #(.DEPTH(MAX_ITEMS), .CNT_W(IW)) u_items (
      .clock(clock), .ctl(itm_ctl), .count(ic_ff), .new_value(req.amount), .head(itm_head)
   );

   always_comb begin
      logic [IW-1:0] ic_new;
      logic [IW-1:0] nl;
      logic [IW-1:0] nh;
      logic [IW:0]   sum;

      state_in    = state_ff;
      cc_in       = cc_ff;
      ic_in       = ic_ff;
      c_in        = c_ff;
      i_in        = i_ff;
      load_in     = load_ff;
      k_in        = k_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      first_in    = first_ff;
      ok_in       = ok_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_lim_in  = rsp_lim_ff;
      rsp_time_in = rsp_time_ff;
      car_ctl     = '0;
      itm_ctl     = '0;
      ic_new      = ic_ff;
      nl          = low_ff;
      nh          = high_ff;
      sum         = '0;

      if (rsp_vld_ff && rsp.ready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (req.is_item) begin
                  if (ic_ff < IW'(MAX_ITEMS)) begin
                     itm_ctl.insert = 1'b1;
                     ic_new         = ic_ff + 1'b1;
                  end
               end else if (cc_ff < CW'(MAX_CARRIERS)) begin
                  car_ctl.insert = 1'b1;
                  cc_in          = cc_ff + 1'b1;
               end
               ic_in = ic_new;
               if (req.last) begin
                  c_in     = '0;
                  i_in     = '0;
                  load_in  = '0;
                  first_in = 1'b1;
                  if (ic_new == '0) begin
                     k_in     = IW'(1);
                     ok_in    = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     k_in     = ic_new;
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (i_ff == ic_ff) begin
               ok_in    = 1'b1;
               state_in = ST_RESTORE;
            end else if (c_ff == cc_ff) begin
               ok_in    = 1'b0;
               state_in = ST_RESTORE;
            end else if ((car_head < itm_head) || (load_ff == k_ff)) begin
               // move on to the next stronger carrier
               car_ctl.rotate = 1'b1;
               c_in           = c_ff + 1'b1;
               load_in        = '0;
            end else begin
               itm_ctl.rotate = 1'b1;
               i_in           = i_ff + 1'b1;
               load_in        = load_ff + 1'b1;
            end
         end
         ST_RESTORE: begin
            // rotate each chain a full turn so its lightest entry is at the head again
            if (c_ff != CW'(MAX_CARRIERS)) begin
               car_ctl.rotate = 1'b1;
               c_in           = c_ff + 1'b1;
            end
            if (i_ff != IW'(MAX_ITEMS)) begin
               itm_ctl.rotate = 1'b1;
               i_in           = i_ff + 1'b1;
            end
            if ((c_ff == CW'(MAX_CARRIERS)) && (i_ff == IW'(MAX_ITEMS))) begin
               if (first_ff) begin
                  nl = IW'(1);
                  nh = ic_ff;
               end else if (ok_ff) begin
                  nl = low_ff;
                  nh = k_ff;
               end else begin
                  nl = k_ff + 1'b1;
                  nh = high_ff;
               end
               sum      = {1'b0, nl} + {1'b0, nh};
               low_in   = nl;
               high_in  = nh;
               first_in = 1'b0;
               c_in     = '0;
               i_in     = '0;
               load_in  = '0;
               if (first_ff && !ok_ff) begin
                  state_in = ST_DONE;
               end else if (nl < nh) begin
                  k_in     = sum[IW:1];
                  state_in = ST_CHECK;
               end else begin
                  k_in     = nh;
                  ok_in    = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff) begin
               rsp_vld_in  = 1'b1;
               rsp_pos_in  = ok_ff;
               rsp_lim_in  = ok_ff ? LIMIT_W'(k_ff) : '0;
               rsp_time_in = ok_ff ? TIME_W'(k12 + (k12 << 1) - TIME_W'(1)) : '0;
               cc_in       = '0;
               ic_in       = '0;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cc_ff      <= '0;
         ic_ff      <= '0;
         c_ff       <= '0;
         i_ff       <= '0;
         load_ff    <= '0;
         k_ff       <= '0;
         low_ff     <= IW'(1);
         high_ff    <= '0;
         first_ff   <= 1'b0;
         ok_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cc_ff      <= cc_in;
         ic_ff      <= ic_in;
         c_ff       <= c_in;
         i_ff       <= i_in;
         load_ff    <= load_in;
         k_ff       <= k_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         first_ff   <= first_in;
         ok_ff      <= ok_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      rsp_lim_ff  <= rsp_lim_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp.valid             = rsp_vld_ff;
   assign rsp.possible          = rsp_pos_ff;
   assign rsp.per_carrier_limit = rsp_lim_ff;
   assign rsp.total_time        = rsp_time_ff;
endmodule
`default_nettype wire

### hdl/mml_checker.sv
// Port-level checks for min_max_load_assignment, bound to the top level.
// Depends on mml_pkg.
`default_nettype none
module mml_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_last,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_possible,
   input wire logic [mml_pkg::LIMIT_W-1:0]   rsp_limit,
   input wire logic [mml_pkg::TIME_W-1:0]    rsp_time
);
   import mml_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_impossible_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_possible |-> (rsp_limit == '0) && (rsp_time == '0))
      else $error("impossible response carries nonzero fields");

   a_time_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_possible |->
         (rsp_limit != '0) &&
         (rsp_time == TIME_W'(TIME_W'(rsp_limit) * TIME_W'(3) - TIME_W'(1))))
      else $error("total time does not match limit");

   a_search_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("request taken during search");
endmodule

bind min_max_load_assignment mml_checker u_mml_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_last     (req.last),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_possible (rsp.possible),
   .rsp_limit    (rsp.per_carrier_limit),
   .rsp_time     (rsp.total_time)
);
`default_nettype wire

### sim/tb_mml_checker.sv
// Checker for the load assignment block: watches both channels, predicts the
// search result for every request marked last and compares it field by field.
// Depends on mml_pkg and mml_ifs.
module tb_mml_checker (
   input  wire logic  clock,
   input  wire logic  reset,
   mml_req_if         req,
   mml_rsp_if         rsp,
   output int         fail_count,
   output int         pending_count
);
   import mml_pkg::*;

   typedef struct packed {
      logic               possible;
      logic [LIMIT_W-1:0] limit;
      logic [TIME_W-1:0]  duration;
   } answer_type;

   logic [AMOUNT_W-1:0] capacities[$];
   logic [AMOUNT_W-1:0] weights[$];
   answer_type          answers_due[$];

   // Greedy walk: lightest item to the weakest carrier that can lift it.
   function automatic bit greedy_fits(int k);
      int c;
      int i;
      int loads[MAX_CARRIERS_DEF];
      c = 0;
      i = 0;
      foreach (loads[j]) loads[j] = 0;
      while (i < weights.size()) begin
         if (c >= capacities.size()) return 1'b0;
         if (capacities[c] < weights[i]) c++;
         else if (loads[c] < k) begin
            loads[c]++;
            i++;
         end else c++;
      end
      return 1'b1;
   endfunction

   function automatic answer_type search_limit();
      answer_type a;
      int lo;
      int hi;
      int mid;
      a = '0;
      if (weights.size() == 0) begin
         a.possible = 1'b1;
         a.limit = LIMIT_W'(1);
         a.duration = TIME_W'(2);
      end else if (greedy_fits(weights.size())) begin
         lo = 1;
         hi = weights.size();
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (greedy_fits(mid)) hi = mid;
            else lo = mid + 1;
         end
         a.possible = 1'b1;
         a.limit = hi[LIMIT_W-1:0];
         a.duration = TIME_W'(3 * hi - 1);
      end
      return a;
   endfunction

   assign pending_count = answers_due.size();

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) begin
            if (req.is_item) begin
               if (weights.size() < MAX_ITEMS_DEF) weights.push_back(req.amount);
            end else if (capacities.size() < MAX_CARRIERS_DEF) begin
               capacities.push_back(req.amount);
            end
            if (req.last) begin
               capacities.sort();
               weights.sort();
               answers_due.push_back(search_limit());
               capacities.delete();
               weights.delete();
            end
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.possible, rsp.per_carrier_limit, rsp.total_time};
            if (answers_due.size() == 0) begin
               $error("unexpected response");
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (got != want) begin
                  if (got.possible != want.possible)
                     $error("possible: expected %0d, got %0d", want.possible, got.possible);
                  if (got.limit != want.limit)
                     $error("per_carrier_limit: expected %0d, got %0d",
                            want.limit, got.limit);
                  if (got.duration != want.duration)
                     $error("total_time: expected %0d, got %0d",
                            want.duration, got.duration);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### sim/tb_min_max_load_assignment.sv
// Testbench top for min_max_load_assignment: drives sets of capacities and
// weights, stalls the response side at random and reports the verdict.
// Depends on mml_pkg, mml_ifs, the block and tb_mml_checker.
module tb_min_max_load_assignment;
   import mml_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count;
   bit   calm;

   mml_req_if req ();
   mml_rsp_if rsp ();

   min_max_load_assignment dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   tb_mml_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 32);
   endfunction

   // Send one request, with a random gap before it; valid stays up afterwards.
   task automatic send_request(bit is_item, logic [AMOUNT_W-1:0] amount, bit last);
      while (take_break()) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.is_item <= is_item;
      req.amount  <= amount;
      req.last    <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Drop valid and hold until every expected response has come.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
   endtask

   task automatic send_set(int carriers, int items, int span, bit heavy);
      int total;
      int n;
      int c;
      bit as_item;
      logic [AMOUNT_W-1:0] v;
      total = carriers + items;
      c = carriers;
      for (n = 0; n < total; n++) begin
         as_item = (c == 0) || ((total - n > c) && $urandom_range(1));
         if (!as_item) c--;
         v = AMOUNT_W'($urandom_range(span));
         if (heavy && $urandom_range(3) == 0) v = AMOUNT_W'($urandom);
         send_request(as_item, v, n == total - 1);
      end
      if (total == 0) send_request(1'b0, AMOUNT_W'($urandom_range(span)), 1'b1);
   endtask

   always @(posedge clock) begin
      rsp.ready <= reset ? 1'b0 : (calm || ($urandom_range(99) >= 32));
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4000000) begin
         $display("tb_min_max_load_assignment failed");
         $finish;
      end
   end

   initial begin
      int sent;
      int r;
      req.valid = 0;
      req.is_item = 0;
      req.amount = 0;
      req.last = 0;
      rsp.ready = 0;
      cycle_count = 0;
      calm = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed sets
      send_request(1'b1, 24'd5, 1'b1);                 // no carriers, one item
      send_request(1'b0, 24'hFFFFFF, 1'b1);            // empty item set
      send_request(1'b0, 24'd3, 1'b0);
      send_request(1'b1, 24'd9, 1'b1);                 // item heavier than every carrier
      send_request(1'b0, 24'hFFFFFF, 1'b0);
      send_request(1'b0, 24'd0, 1'b0);
      send_request(1'b1, 24'd0, 1'b0);
      send_request(1'b1, 24'hFFFFFF, 1'b0);
      send_request(1'b1, 24'h000000, 1'b1);
      send_request(1'b0, 24'h555555, 1'b0);
      send_request(1'b0, 24'hAAAAAA, 1'b0);
      send_request(1'b1, 24'h555555, 1'b0);
      send_request(1'b1, 24'hAAAAAA, 1'b0);
      send_request(1'b1, 24'h000001, 1'b1);
      // full carrier store: drops values, last on a dropped one
      for (int n = 0; n < MAX_CARRIERS_DEF + 2; n++)
         send_request(1'b0, AMOUNT_W'($urandom_range(50)), 1'b0);
      for (int n = 0; n < 6; n++) send_request(1'b1, AMOUNT_W'($urandom_range(60)), 1'b0);
      send_request(1'b0, 24'd1, 1'b1);
      drain();

      sent = 0;
      while (sent < 650) begin
         calm = (sent > 250 && sent < 370);
         r = $urandom_range(9);
         if (r == 0) begin
            send_set(0, $urandom_range(3), 20, 1'b1);
            sent += 2;
         end else begin
            int c;
            int i;
            c = $urandom_range(1, 8);
            i = $urandom_range(0, 20);
            send_set(c, i, (r < 5) ? 40 : 1000, r == 9);
            sent += c + i;
         end
         if (sent > 300 && sent < 330) drain();
      end
      calm = 0;
      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_min_max_load_assignment passed");
      end else begin
         $display("tb_min_max_load_assignment failed");
      end
      $finish;
   end
endmodule
